// ===== design/tmr_pkg.sv =====
// Shared types, register offsets and codes for the down-counter timer.
`timescale 1ns / 1ps
`default_nettype none
package tmr_pkg;

  // Counter register width; the bus always sees the low 32 bits.
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned BUS_WIDTH   = 32;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [BUS_WIDTH-1:0]   bus_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_HALF  = 2'd1,
    SIZE_WORD  = 2'd2,
    SIZE_WORD3 = 2'd3
  } size_t;

  // Word index (offset bits 3:2) of each register.
  localparam logic [1:0] WIDX_CONTROL   = 2'd0;
  localparam logic [1:0] WIDX_INTERVAL  = 2'd1;
  localparam logic [1:0] WIDX_REMAINING = 2'd2;
  localparam logic [1:0] WIDX_NONE      = 2'd3;

  localparam bus_t BYTE_MASK = 32'h0000_00FF;
  localparam bus_t HALF_MASK = 32'h0000_FFFF;
  localparam bus_t WORD_MASK = 32'hFFFF_FFFF;

  // Control bit positions.
  localparam int unsigned CTRL_W      = 3;
  localparam int unsigned CTRL_ENABLE = 0;
  localparam int unsigned CTRL_PERIOD = 1;
  localparam int unsigned CTRL_IRQ    = 2;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] offset;
    logic [1:0] access_size;
    bus_t       write_data;
  } item_t;

  typedef struct packed {
    bus_t read_data;
    logic interrupt_pulse;
    logic access_error;
    logic timer_enabled;
  } result_t;

endpackage : tmr_pkg
`default_nettype wire

// ===== design/tmr_if.sv =====
// Valid/ready channel interfaces for timer input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface tmr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  offset;
  logic [1:0]  access_size;
  logic [31:0] write_data;

  modport source (output valid, mode, offset, access_size, write_data, input ready);
  modport sink   (input valid, mode, offset, access_size, write_data, output ready);
endinterface : tmr_in_if

interface tmr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        interrupt_pulse;
  logic        access_error;
  logic        timer_enabled;

  modport source (output valid, read_data, interrupt_pulse, access_error, timer_enabled,
                  input ready);
  modport sink   (input valid, read_data, interrupt_pulse, access_error, timer_enabled,
                  output ready);
endinterface : tmr_out_if
`default_nettype wire

// ===== design/tmr_in_stage.sv =====
// Input register: captures one item, released when the core advances.
`timescale 1ns / 1ps
`default_nettype none
module tmr_in_stage
  import tmr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  take,
  input  wire item_t item_in,
  input  wire logic  advance,
  output logic       ready,
  output logic       valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign ready     = !valid_r || advance;
  assign valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_in;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule : tmr_in_stage
`default_nettype wire

// ===== design/tmr_core.sv =====
// Timer registers plus the single-pass tick/read/write update logic.
`timescale 1ns / 1ps
`default_nettype none
module tmr_core
  import tmr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  advance,
  input  wire item_t item,
  output result_t    result
);

  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  cnt_t              intv_r, intv_nxt;
  cnt_t              rem_r, rem_nxt;

  logic       is_access, is_word, lane_bad, err;
  logic [1:0] widx, lane;
  logic [4:0] shamt;
  bus_t       lane_mask, cur, merged, wr_mask;
  cnt_t       dec;
  logic       pulse;

  always_comb begin
    widx      = item.offset[3:2];
    lane      = item.offset[1:0];
    shamt     = {lane, 3'b000};
    is_access = (item.mode == MODE_READ) || (item.mode == MODE_WRITE);
    is_word   = item.access_size[1];

    case (item.access_size)
      SIZE_BYTE: lane_mask = BYTE_MASK;
      SIZE_HALF: lane_mask = HALF_MASK;
      default:   lane_mask = WORD_MASK;
    endcase

    lane_bad = is_word && (lane != 2'd0);
    err      = is_access && ((widx == WIDX_NONE) || lane_bad);

    unique case (widx)
      WIDX_CONTROL:   cur = BUS_WIDTH'(ctrl_r);
      WIDX_INTERVAL:  cur = BUS_WIDTH'(intv_r);
      WIDX_REMAINING: cur = BUS_WIDTH'(rem_r);
      default:        cur = '0;
    endcase

    wr_mask = lane_mask << shamt;
    merged  = (cur & ~wr_mask) | ((item.write_data & lane_mask) << shamt);
    dec     = (rem_r != '0) ? rem_r - cnt_t'(1) : rem_r;

    ctrl_nxt = ctrl_r;
    intv_nxt = intv_r;
    rem_nxt  = rem_r;
    pulse    = 1'b0;
    result.read_data = '0;

    if (item.mode == MODE_TICK) begin
      if (ctrl_r[CTRL_ENABLE] && (intv_r != '0)) begin
        rem_nxt = dec;
        if (dec == '0) begin
          pulse = ctrl_r[CTRL_IRQ];
          if (ctrl_r[CTRL_PERIOD]) begin
            rem_nxt = intv_r;
          end else begin
            ctrl_nxt[CTRL_ENABLE] = 1'b0;
          end
        end
      end
    end else if (is_access && !err) begin
      if (item.mode == MODE_READ) begin
        result.read_data = (cur >> shamt) & lane_mask;
      end else begin
        unique case (widx)
          WIDX_CONTROL: begin
            ctrl_nxt = merged[CTRL_W-1:0];
            if (merged[CTRL_ENABLE]) begin
              if (rem_r == '0) rem_nxt = intv_r;
            end else begin
              rem_nxt = '0;
            end
          end
          WIDX_INTERVAL: begin
            intv_nxt = cnt_t'(merged);
            if (ctrl_r[CTRL_ENABLE]) rem_nxt = cnt_t'(merged);
          end
          WIDX_REMAINING: rem_nxt = cnt_t'(merged);
          default: ;
        endcase
      end
    end

    result.interrupt_pulse = pulse;
    result.access_error    = err;
    result.timer_enabled   = ctrl_nxt[CTRL_ENABLE];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      intv_r <= '0;
      rem_r  <= '0;
    end else if (advance) begin
      ctrl_r <= ctrl_nxt;
      intv_r <= intv_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule : tmr_core
`default_nettype wire

// ===== design/tmr_out_stage.sv =====
// Result register: holds one result item until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module tmr_out_stage
  import tmr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_in,
  input  wire logic    taken,
  output logic         free,
  output logic         valid,
  output result_t      res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free      = !valid_r || taken;
  assign valid_nxt = load ? 1'b1 : (taken ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid = valid_r;
  assign res   = res_r;

endmodule : tmr_out_stage
`default_nettype wire

// ===== design/timer_down_counter_regs.sv =====
// Top level of the memory-mapped down-counter timer.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+--------------------------------------------
//   in_bus   | in  | valid/ready           | mode, offset, access_size, write_data
//   out_bus  | out | valid/ready           | read_data, interrupt_pulse, access_error,
//            |     |                       | timer_enabled
//
// One item per cycle sustained while results are taken: input register -> one pass of
// update logic -> result register. An accepted item waits in the input register until
// the result register is free, then its result is registered there.
// Timer state (control, interval, remaining) updates when an item moves into the
// result register, so items are applied strictly in order.
// Synchronous active-low reset clears control, interval, remaining and both valids.
// A stalled result holds; one more item may wait in the input register behind it.
`timescale 1ns / 1ps
`default_nettype none
module timer_down_counter_regs
  import tmr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  tmr_in_if.sink    in_bus,
  tmr_out_if.source out_bus
);

  item_t   in_item, stage_item;
  logic    in_take, stage_valid, stage_ready;
  logic    out_free, advance;
  result_t core_res, out_res;

  assign in_item.mode        = in_bus.mode;
  assign in_item.offset      = in_bus.offset;
  assign in_item.access_size = in_bus.access_size;
  assign in_item.write_data  = in_bus.write_data;

  assign in_take      = in_bus.valid && stage_ready;
  assign in_bus.ready = stage_ready;

  // The item in the input register is worked on as soon as the result slot is free.
  assign advance = stage_valid && out_free;

  tmr_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_take),
    .item_in (in_item),
    .advance (advance),
    .ready   (stage_ready),
    .valid   (stage_valid),
    .item    (stage_item)
  );

  tmr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (stage_item),
    .result  (core_res)
  );

  tmr_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance),
    .res_in (core_res),
    .taken  (out_bus.ready),
    .free   (out_free),
    .valid  (out_bus.valid),
    .res    (out_res)
  );

  assign out_bus.read_data       = out_res.read_data;
  assign out_bus.interrupt_pulse = out_res.interrupt_pulse;
  assign out_bus.access_error    = out_res.access_error;
  assign out_bus.timer_enabled   = out_res.timer_enabled;

endmodule : timer_down_counter_regs
`default_nettype wire

// ===== verif/timer_down_counter_regs_tb.sv =====
// Self-checking testbench for the timer_down_counter_regs register block.
`timescale 1ns / 1ps
`default_nettype none
module timer_down_counter_regs_tb;
  import tmr_pkg::*;

  // Watchdog: cycles with no item moving on either channel.
  // Covers the long receiver hold-off plus the worst idle gaps on both sides.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Cycles let pass after the last result.
  localparam int unsigned DRAIN_CYCLES = 10;
  // Receiver hold-off in the backpressure test.
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_GAP      = 13;

  // Byte offsets of the registers in the device window.
  localparam logic [3:0] OFS_CONTROL   = {WIDX_CONTROL, 2'b00};
  localparam logic [3:0] OFS_INTERVAL  = {WIDX_INTERVAL, 2'b00};
  localparam logic [3:0] OFS_REMAINING = {WIDX_REMAINING, 2'b00};
  localparam logic [3:0] OFS_HOLE      = {WIDX_NONE, 2'b00};

  // Control register values.
  localparam bus_t CTL_EN     = bus_t'(1) << CTRL_ENABLE;
  localparam bus_t CTL_PER    = bus_t'(1) << CTRL_PERIOD;
  localparam bus_t CTL_IRQ_EN = bus_t'(1) << CTRL_IRQ;

  logic clk = 1'b0;
  logic rst_n;

  tmr_in_if  in_bus ();
  tmr_out_if out_bus ();

  timer_down_counter_regs u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Timer shadow state, advanced once per accepted input item.
  // ---------------------------------------------------------------------------
  logic [CTRL_W-1:0] timer_ctrl      = '0;
  cnt_t              timer_interval  = '0;
  cnt_t              timer_remaining = '0;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  int unsigned fail_count      = 0;
  bit          in_idle         = 1'b1;  // sender draws random gaps
  bit          out_idle        = 1'b1;  // receiver draws random stalls
  int unsigned out_hold_cycles = 0;     // one-shot long hold-off request

  // Bus view of a register: low 32 bits, zero-extended control.
  function automatic bus_t timer_reg_view(logic [1:0] widx);
    case (widx)
      WIDX_CONTROL:   return bus_t'(timer_ctrl);
      WIDX_INTERVAL:  return bus_t'(timer_interval);
      WIDX_REMAINING: return bus_t'(timer_remaining);
      default:        return '0;
    endcase
  endfunction

  // Applies one item to the shadow state and returns the result it must produce.
  function automatic result_t timer_step(item_t it);
    result_t    res;
    logic [1:0] widx;
    int unsigned sh;
    logic       is_word;
    bus_t       lmask;
    bus_t       m;
    bus_t       merged;
    res     = '0;
    widx    = it.offset[3:2];
    sh      = it.offset[1:0] * 8;
    is_word = it.access_size[1];  // size three acts as word
    lmask   = is_word ? WORD_MASK : (it.access_size == SIZE_HALF ? HALF_MASK : BYTE_MASK);
    case (mode_t'(it.mode)) inside
      MODE_TICK: begin
        // Only an enabled timer with a nonzero interval counts.
        if (timer_ctrl[CTRL_ENABLE] && timer_interval != '0) begin
          if (timer_remaining != '0) timer_remaining = timer_remaining - 1'b1;
          if (timer_remaining == '0) begin
            res.interrupt_pulse = timer_ctrl[CTRL_IRQ];
            if (timer_ctrl[CTRL_PERIOD]) timer_remaining = timer_interval;
            else timer_ctrl[CTRL_ENABLE] = 1'b0;
          end
        end
      end
      MODE_READ, MODE_WRITE: begin
        if (widx == WIDX_NONE || (is_word && it.offset[1:0] != 2'b00)) begin
          res.access_error = 1'b1;
        end else if (mode_t'(it.mode) == MODE_READ) begin
          res.read_data = (timer_reg_view(widx) >> sh) & lmask;
        end else begin
          // Lanes above bit 31 fall off, so halfword at lane three touches one byte.
          m      = lmask << sh;
          merged = (timer_reg_view(widx) & ~m) | ((it.write_data & lmask) << sh);
          case (widx)
            WIDX_CONTROL: begin
              timer_ctrl = merged[CTRL_W-1:0];
              if (!timer_ctrl[CTRL_ENABLE]) timer_remaining = '0;
              else if (timer_remaining == '0) timer_remaining = timer_interval;
            end
            WIDX_INTERVAL: begin
              timer_interval = cnt_t'(merged);
              if (timer_ctrl[CTRL_ENABLE]) timer_remaining = timer_interval;
            end
            default: timer_remaining = cnt_t'(merged);
          endcase
        end
      end
      default: ;  // no-op mode
    endcase
    res.timer_enabled = timer_ctrl[CTRL_ENABLE];
    return res;
  endfunction

  function automatic item_t make_item(mode_t mode, logic [3:0] ofs, size_t size, bus_t data);
    item_t it;
    it.mode        = mode;
    it.offset      = ofs;
    it.access_size = size;
    it.write_data  = data;
    return it;
  endfunction

  // Mostly well-formed traffic: ticks, register accesses with small counts
  // so the timer expires often, and a tail of fully random noise.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    logic [1:0]  widx;
    logic [1:0]  lane;
    it   = make_item(MODE_TICK, OFS_CONTROL, SIZE_WORD, $urandom());
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 90) begin
      it.mode = (pick < 65) ? MODE_READ : MODE_WRITE;
      widx    = 2'($urandom_range(0, 2));
      lane    = 2'b00;
      if ($urandom_range(0, 3) == 0) begin
        it.access_size = 2'($urandom_range(0, 1));
        lane           = 2'($urandom_range(0, 3));
      end else if ($urandom_range(0, 7) == 0) begin
        it.access_size = SIZE_WORD3;
      end
      it.offset = {widx, lane};
      if (it.mode == MODE_WRITE && widx != WIDX_CONTROL && $urandom_range(0, 3) != 0)
        it.write_data = $urandom_range(0, 12);
    end else if (pick >= 90) begin
      it.mode        = 2'($urandom_range(0, 3));
      it.offset      = 4'($urandom_range(0, 15));
      it.access_size = 2'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // Offers one item, starting and ending at a falling edge. Valid stays high
  // on return so back-to-back items never drop it.
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= it.mode;
    in_bus.offset      <= it.offset;
    in_bus.access_size <= it.access_size;
    in_bus.write_data  <= it.write_data;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pending_results.push_back(timer_step(it));
    @(negedge clk);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    send_item(make_item(MODE_READ, OFS_CONTROL, SIZE_WORD, '0));
    send_item(make_item(MODE_READ, OFS_INTERVAL, SIZE_WORD, '0));
    send_item(make_item(MODE_READ, OFS_REMAINING, SIZE_WORD, '0));
  endtask

  task automatic test_periodic_expiry();
    send_item(make_item(MODE_WRITE, OFS_INTERVAL, SIZE_WORD, 32'd3));
    // Enable with remaining at zero: counter reloads from interval.
    send_item(make_item(MODE_WRITE, OFS_CONTROL, SIZE_WORD, CTL_EN | CTL_PER | CTL_IRQ_EN));
    repeat (3) send_item(make_item(MODE_TICK, OFS_CONTROL, SIZE_WORD, '0));
    send_item(make_item(MODE_READ, OFS_REMAINING, SIZE_WORD, '0));
    // Interval write while enabled reloads the counter.
    send_item(make_item(MODE_WRITE, OFS_INTERVAL, SIZE_WORD, 32'd2));
    repeat (2) send_item(make_item(MODE_TICK, OFS_CONTROL, SIZE_WORD, '0));
  endtask

  task automatic test_one_shot();
    // Upper junk bits must be dropped; counter nonzero so no reload.
    send_item(make_item(MODE_WRITE, OFS_CONTROL, SIZE_WORD,
                        32'hFFFF_FFF8 | CTL_EN | CTL_IRQ_EN));
    repeat (3) send_item(make_item(MODE_TICK, OFS_CONTROL, SIZE_WORD, '0));
    // Zero interval: enabled timer must not count.
    send_item(make_item(MODE_WRITE, OFS_INTERVAL, SIZE_WORD, '0));
    send_item(make_item(MODE_WRITE, OFS_CONTROL, SIZE_WORD, CTL_EN));
    send_item(make_item(MODE_TICK, OFS_CONTROL, SIZE_WORD, '0));
  endtask

  task automatic test_access_errors();
    send_item(make_item(MODE_READ, OFS_HOLE, SIZE_WORD, '0));
    send_item(make_item(MODE_WRITE, OFS_HOLE | 4'h3, SIZE_BYTE, 32'hFFFF_FFFF));
    send_item(make_item(MODE_READ, OFS_CONTROL | 4'h2, SIZE_WORD, '0));   // unaligned
    send_item(make_item(MODE_WRITE, OFS_INTERVAL | 4'h1, SIZE_WORD3, 32'hFFFF_FFFF));
    send_item(make_item(MODE_NOP, 4'hF, SIZE_WORD3, 32'hFFFF_FFFF));
  endtask

  task automatic test_subword_lanes();
    send_item(make_item(MODE_WRITE, OFS_INTERVAL | 4'h3, SIZE_BYTE, 32'hFFFF_FFFF));
    send_item(make_item(MODE_WRITE, OFS_REMAINING | 4'h3, SIZE_HALF, 32'h0000_ABCD));
    send_item(make_item(MODE_WRITE, OFS_REMAINING | 4'h1, SIZE_HALF, 32'h1234_5678));
    send_item(make_item(MODE_READ, OFS_INTERVAL | 4'h3, SIZE_HALF, '0));
    send_item(make_item(MODE_READ, OFS_REMAINING | 4'h1, SIZE_BYTE, '0));
    send_item(make_item(MODE_READ, OFS_REMAINING | 4'h2, SIZE_HALF, '0));
    // Disable clears the counter.
    send_item(make_item(MODE_WRITE, OFS_CONTROL, SIZE_BYTE, '0));
    send_item(make_item(MODE_READ, OFS_REMAINING, SIZE_WORD3, '0));
  endtask

  // ---------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_random(1000);
  endtask

  task automatic test_back_to_back();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    send_random(250);
  endtask

  // Receiver holds off while the sender streams, so the block fills and
  // drops in_bus.ready.
  task automatic test_backpressure();
    in_idle         = 1'b0;
    out_idle        = 1'b1;
    out_hold_cycles = HOLD_CYCLES;
    send_random(170);
    in_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (out_hold_cycles != 0) begin
        out_bus.ready <= 1'b0;
        repeat (out_hold_cycles) @(negedge clk);
        out_hold_cycles = 0;
      end else begin
        stall = out_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (stall != 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_bus.ready <= 1'b1;
        do @(posedge clk); while (!(rst_n === 1'b1 && out_bus.valid === 1'b1));
        @(negedge clk);
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: read_data %h", out_bus.read_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %h, got %h", want.read_data,
                 out_bus.read_data);
          fail_count++;
        end
        if (out_bus.interrupt_pulse !== want.interrupt_pulse) begin
          $error("interrupt_pulse mismatch: expected %b, got %b", want.interrupt_pulse,
                 out_bus.interrupt_pulse);
          fail_count++;
        end
        if (out_bus.access_error !== want.access_error) begin
          $error("access_error mismatch: expected %b, got %b", want.access_error,
                 out_bus.access_error);
          fail_count++;
        end
        if (out_bus.timer_enabled !== want.timer_enabled) begin
          $error("timer_enabled mismatch: expected %b, got %b", want.timer_enabled,
                 out_bus.timer_enabled);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on handshake progress.
  always @(posedge clk) begin
    int unsigned quiet;
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.mode        <= MODE_TICK;
    in_bus.offset      <= '0;
    in_bus.access_size <= SIZE_BYTE;
    in_bus.write_data  <= '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_periodic_expiry();
    test_one_shot();
    test_access_errors();
    test_subword_lanes();
    test_random_traffic();
    test_back_to_back();
    test_backpressure();

    // Drain: every owed result must show up, then nothing more.
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : timer_down_counter_regs_tb
`default_nettype wire
